// ===== sv/vrt_pkg.sv =====
// Shared types and constants for the 3-D voxel ray traversal block.
// No dependencies.
package vrt_pkg;

  localparam int MaxSteps   = 63;
  localparam int StepW      = 6;
  localparam int TFracBits  = 24;
  localparam int TW         = 48;
  localparam int CellW      = 24;
  localparam int CoordW     = 32;
  localparam int SizeW      = 31;
  localparam int MinCell    = 256;
  localparam int DivNW      = 56;
  localparam int DivDW      = 33;
  localparam int DivCntW    = 6;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_CELL0,
    OP_CELL1,
    OP_TNEXT,
    OP_TCELL
  } op_t;

  typedef struct packed {
    logic              start;
    logic [DivNW-1:0]  dividend;
    logic [DivDW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DivNW-1:0]  quot;
    logic [DivDW-1:0]  rem;
  } div_rsp_t;

endpackage

// ===== sv/vrt_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on vrt_pkg.
module vrt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  vrt_pkg::div_req_t req,
  output vrt_pkg::div_rsp_t rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [vrt_pkg::DivCntW-1:0]  cnt_r, cnt_nxt;
  logic [vrt_pkg::DivNW-1:0]    q_r, q_nxt;
  logic [vrt_pkg::DivDW-1:0]    rem_r, rem_nxt;
  logic [vrt_pkg::DivDW-1:0]    den_r, den_nxt;
  logic [vrt_pkg::DivDW:0]      trial;
  logic                         fit;

  assign trial = {rem_r, q_r[vrt_pkg::DivNW-1]};
  assign fit   = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[vrt_pkg::DivNW-2:0], fit};
      rem_nxt = fit ? vrt_pkg::DivDW'(trial - {1'b0, den_r})
                    : trial[vrt_pkg::DivDW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == vrt_pkg::DivCntW'(vrt_pkg::DivNW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

  property p_no_restart;
    @(posedge clk) disable iff (!rst_n) busy_r |-> !req.start;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

  property p_done_idle;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r;
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("divider done while busy");

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without run");

endmodule

// ===== sv/voxel_ray_traversal_3d.sv =====
// Top level of the 3-D voxel ray traversal block: setup sequencer and cell stepper.
// Depends on vrt_pkg and vrt_div.
//
//  channel | ports                            | direction
//  in      | in_valid, in_stall, in_start_*, in_end_*  | ray in
//  out     | out_valid, out_stall, out_cell_*, out_last, out_truncated | cells out
//  cfg     | cfg_we, cfg_index, cfg_wdata     | cell sizes in
//
// Setup runs twelve divisions on the shared divider, one after another.
// Then one cell per cycle, up to 64 cells, when the output is not stalled.
// in_stall is high from acceptance until the last cell is loaded into the output register.
// Reset is synchronous; it restores cell sizes to 1.0 and empties the output.
module voxel_ray_traversal_3d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_start_z,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  input  logic [31:0] in_end_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_cell_x,
  output logic [23:0] out_cell_y,
  output logic [23:0] out_cell_z,
  output logic        out_last,
  output logic        out_truncated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  localparam int CW = vrt_pkg::CellW;
  localparam int TW = vrt_pkg::TW;

  vrt_pkg::state_t state_r, state_nxt;
  vrt_pkg::op_t    op_r;
  logic [1:0]      axis_r;

  logic [vrt_pkg::SizeW-1:0]  size_r [3];
  logic [vrt_pkg::CoordW-1:0] p0_r [3];
  logic [vrt_pkg::CoordW-1:0] p1_r [3];
  logic [CW-1:0]              cell_r [3];
  logic [1:0]                 sgn_r [3];
  logic [TW-1:0]              tnb_r [3];
  logic [TW-1:0]              tpc_r [3];
  logic signed [25:0]         c0_r;
  logic [vrt_pkg::SizeW-1:0]  rem0_r;
  logic [26:0]                total_r;
  logic [vrt_pkg::StepW-1:0]  steps_r;
  logic                       cut_r;

  logic        out_valid_r;
  logic [CW-1:0] ocx_r, ocy_r, ocz_r;
  logic        olast_r, otrunc_r;

  vrt_pkg::div_req_t dreq;
  vrt_pkg::div_rsp_t drsp;

  vrt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [vrt_pkg::SizeW-1:0]  s_ax;
  logic [vrt_pkg::CoordW-1:0] p0, p1, pabs;
  logic signed [32:0]         d;
  logic [32:0]                dabs;
  logic                       dpos, dzero, pneg, rnz;
  logic [vrt_pkg::SizeW-1:0]  num, rem_adj;
  logic signed [25:0]         qs, cval, cdiff;
  logic [25:0]                cdabs;
  logic [TW-1:0]              tsat;
  logic                       accept_in, emit;
  logic [1:0]                 best;
  logic                       have_best;
  logic [TW:0]                tsum;

  assign s_ax  = (size_r[axis_r] < vrt_pkg::SizeW'(vrt_pkg::MinCell))
                 ? vrt_pkg::SizeW'(vrt_pkg::MinCell) : size_r[axis_r];
  assign p0    = p0_r[axis_r];
  assign p1    = p1_r[axis_r];
  assign d     = $signed({p1[31], p1}) - $signed({p0[31], p0});
  assign dzero = (d == '0);
  assign dpos  = !d[32] && !dzero;
  assign dabs  = d[32] ? 33'(-d) : 33'(d);
  assign pneg  = (op_r == vrt_pkg::OP_CELL0) ? p0[31] : p1[31];
  assign pabs  = (op_r == vrt_pkg::OP_CELL0) ? (p0[31] ? 32'(-p0) : p0)
                                              : (p1[31] ? 32'(-p1) : p1);
  assign num   = dpos ? vrt_pkg::SizeW'(s_ax - rem0_r) : rem0_r;

  always_comb begin
    dreq.start = (state_r == vrt_pkg::ST_DIV_GO);
    unique case (op_r)
      vrt_pkg::OP_CELL0, vrt_pkg::OP_CELL1: begin
        dreq.dividend = {24'd0, pabs};
        dreq.divisor  = {2'd0, s_ax};
      end
      vrt_pkg::OP_TNEXT: begin
        dreq.dividend = {1'b0, num, 24'd0};
        dreq.divisor  = dabs;
      end
      default: begin
        dreq.dividend = {1'b0, s_ax, 24'd0};
        dreq.divisor  = dabs;
      end
    endcase
  end

  assign rnz     = (drsp.rem != '0);
  assign qs      = $signed({1'b0, drsp.quot[24:0]});
  assign cval    = pneg ? (rnz ? -qs - 26'sd1 : -qs) : qs;
  assign rem_adj = (pneg && rnz) ? vrt_pkg::SizeW'(s_ax - drsp.rem[30:0]) : drsp.rem[30:0];
  assign cdiff   = cval - c0_r;
  assign cdabs   = cdiff[25] ? 26'(-cdiff) : 26'(cdiff);
  assign tsat    = (drsp.quot[vrt_pkg::DivNW-1:TW] != '0) ? '1 : drsp.quot[TW-1:0];

  always_comb begin
    best      = 2'd0;
    have_best = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (sgn_r[a] != 2'd0 && (!have_best || tnb_r[a] < tnb_r[best])) begin
        best      = 2'(a);
        have_best = 1'b1;
      end
    end
  end
  assign tsum = {1'b0, tnb_r[best]} + {1'b0, tpc_r[best]};

  assign accept_in = in_valid && !in_stall;
  assign emit      = (state_r == vrt_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vrt_pkg::ST_IDLE:     if (accept_in) state_nxt = vrt_pkg::ST_DIV_GO;
      vrt_pkg::ST_DIV_GO:   state_nxt = vrt_pkg::ST_DIV_WAIT;
      vrt_pkg::ST_DIV_WAIT: begin
        if (drsp.done) begin
          state_nxt = (op_r == vrt_pkg::OP_TCELL && axis_r == 2'd2)
                      ? vrt_pkg::ST_EMIT : vrt_pkg::ST_DIV_GO;
        end
      end
      default:              if (emit && steps_r == '0) state_nxt = vrt_pkg::ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != vrt_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vrt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= vrt_pkg::OP_CELL0;
      axis_r      <= 2'd0;
      for (int a = 0; a < 3; a++) size_r[a] <= vrt_pkg::SizeW'(65536);
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index <= vrt_pkg::REG_SIZE_Z) size_r[cfg_index] <= cfg_wdata;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (accept_in) begin
        op_r   <= vrt_pkg::OP_CELL0;
        axis_r <= 2'd0;
      end else if (state_r == vrt_pkg::ST_DIV_WAIT && drsp.done) begin
        op_r <= vrt_pkg::op_t'(op_r + 2'd1);
        if (op_r == vrt_pkg::OP_TCELL && axis_r != 2'd2) axis_r <= axis_r + 2'd1;
      end
    end

    if (accept_in) begin
      p0_r[0] <= in_start_x; p0_r[1] <= in_start_y; p0_r[2] <= in_start_z;
      p1_r[0] <= in_end_x;   p1_r[1] <= in_end_y;   p1_r[2] <= in_end_z;
      total_r <= '0;
    end

    if (state_r == vrt_pkg::ST_DIV_WAIT && drsp.done) begin
      unique case (op_r)
        vrt_pkg::OP_CELL0: begin
          c0_r           <= cval;
          rem0_r         <= rem_adj;
          cell_r[axis_r] <= cval[CW-1:0];
          sgn_r[axis_r]  <= dzero ? 2'd0 : (dpos ? 2'd1 : 2'd3);
        end
        vrt_pkg::OP_CELL1: total_r <= total_r + {1'b0, cdabs};
        vrt_pkg::OP_TNEXT: tnb_r[axis_r] <= dzero ? '0 : tsat;
        default: begin
          tpc_r[axis_r] <= dzero ? '0 : tsat;
          if (axis_r == 2'd2) begin
            cut_r   <= total_r > 27'(vrt_pkg::MaxSteps);
            steps_r <= (total_r > 27'(vrt_pkg::MaxSteps))
                       ? vrt_pkg::StepW'(vrt_pkg::MaxSteps) : total_r[vrt_pkg::StepW-1:0];
          end
        end
      endcase
    end

    if (emit) begin
      ocx_r    <= cell_r[0];
      ocy_r    <= cell_r[1];
      ocz_r    <= cell_r[2];
      olast_r  <= (steps_r == '0);
      otrunc_r <= cut_r;
      if (steps_r != '0) begin
        steps_r <= steps_r - 1'b1;
        if (have_best) begin
          cell_r[best] <= (sgn_r[best] == 2'd1) ? cell_r[best] + 1'b1 : cell_r[best] - 1'b1;
          tnb_r[best]  <= tsum[TW] ? '1 : tsum[TW-1:0];
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_x    = ocx_r;
  assign out_cell_y    = ocy_r;
  assign out_cell_z    = ocz_r;
  assign out_last      = olast_r;
  assign out_truncated = otrunc_r;

  property p_start_in_go;
    @(posedge clk) disable iff (!rst_n) dreq.start |=> state_r == vrt_pkg::ST_DIV_WAIT;
  endproperty
  a_start_in_go: assert property (p_start_in_go) else $error("divider start out of sequence");

  property p_last_to_idle;
    @(posedge clk) disable iff (!rst_n)
      (emit && steps_r == '0) |=> state_r == vrt_pkg::ST_IDLE;
  endproperty
  a_last_to_idle: assert property (p_last_to_idle) else $error("no return to idle");

  property p_steps_bound;
    @(posedge clk) disable iff (!rst_n)
      state_r == vrt_pkg::ST_EMIT |-> steps_r <= vrt_pkg::StepW'(vrt_pkg::MaxSteps);
  endproperty
  a_steps_bound: assert property (p_steps_bound) else $error("step count out of range");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for voxel_ray_traversal_3d: random and directed rays,
// predicted cell sequences compared in order. Depends on vrt_pkg and the block.
`timescale 1ns / 100ps

module testbench;

  localparam longint TSat = (64'd1 << vrt_pkg::TW) - 1;
  localparam int CycleLimit = 1500000;
  localparam int HoldCycles = 3000;

  typedef struct packed {
    logic [vrt_pkg::CellW-1:0] cx;
    logic [vrt_pkg::CellW-1:0] cy;
    logic [vrt_pkg::CellW-1:0] cz;
    logic                      last;
    logic                      trunc;
  } cell_t;

  class cell_scoreboard;
    cell_t  pending[$];
    longint size_q[3];
    int     mismatches;

    function void set_size(int a, logic [30:0] v);
      size_q[a] = v;
    endfunction

    function longint quot_t(longint num, longint den);
      longint q, r, f;
      q = num / den;
      if (q > (TSat >> vrt_pkg::TFracBits)) return TSat;
      r = num % den;
      f = 0;
      for (int i = 0; i < vrt_pkg::TFracBits; i++) begin
        r = r <<< 1;
        f = f <<< 1;
        if (r >= den) begin
          r = r - den;
          f = f | 1;
        end
      end
      return (q <<< vrt_pkg::TFracBits) | f;
    endfunction

    function longint fdiv(longint a, longint s);
      longint q;
      q = a / s;
      if ((a % s) != 0 && a < 0) q = q - 1;
      return q;
    endfunction

    function void note_ray(logic [31:0] p[6]);
      longint s, p0, p1, c0, c1, d, da, num, total, tn[3], tc[3];
      logic [vrt_pkg::CellW-1:0] cur[3];
      int dir[3];
      int n, best;
      bit cut;
      cell_t e;
      total = 0;
      for (int a = 0; a < 3; a++) begin
        s = size_q[a] < vrt_pkg::MinCell ? vrt_pkg::MinCell : size_q[a];
        p0 = longint'(signed'(p[a]));
        p1 = longint'(signed'(p[a+3]));
        c0 = fdiv(p0, s);
        c1 = fdiv(p1, s);
        d = p1 - p0;
        total += (c1 > c0) ? c1 - c0 : c0 - c1;
        cur[a] = c0[vrt_pkg::CellW-1:0];
        dir[a] = 0; tn[a] = 0; tc[a] = 0;
        if (d != 0) begin
          da = d > 0 ? d : -d;
          num = d > 0 ? s * (c0 + 1) - p0 : p0 - s * c0;
          dir[a] = d > 0 ? 1 : -1;
          tn[a] = quot_t(num, da);
          tc[a] = quot_t(s, da);
        end
      end
      cut = total > vrt_pkg::MaxSteps;
      n = (cut ? vrt_pkg::MaxSteps : int'(total)) + 1;
      for (int k = 0; k < n; k++) begin
        e.cx = cur[0]; e.cy = cur[1]; e.cz = cur[2];
        e.last = (k == n - 1);
        e.trunc = cut;
        pending = {pending, e};
        best = -1;
        for (int a = 0; a < 3; a++)
          if (dir[a] != 0 && (best < 0 || tn[a] < tn[best])) best = a;
        if (best >= 0) begin
          cur[best] = vrt_pkg::CellW'(cur[best] + dir[best]);
          tn[best] = (tn[best] + tc[best] > TSat) ? TSat : tn[best] + tc[best];
        end
      end
    endfunction

    function void check_cell(cell_t got);
      cell_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cell %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"cell mismatch: expected x=%h y=%h z=%h l=%b t=%b",
                    " got x=%h y=%h z=%h l=%b t=%b"},
                   want.cx, want.cy, want.cz, want.last, want.trunc,
                   got.cx, got.cy, got.cz, got.last, got.trunc);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_stall = 0, cfg_we = 0;
  logic in_stall, out_valid, out_last, out_truncated;
  logic [31:0] in_start_x = 0, in_start_y = 0, in_start_z = 0;
  logic [31:0] in_end_x = 0, in_end_y = 0, in_end_z = 0;
  logic [23:0] out_cell_x, out_cell_y, out_cell_z;
  logic [1:0] cfg_index = 0;
  logic [30:0] cfg_wdata = 0;
  cell_scoreboard sb;
  int cycles = 0;
  int hold_off = 0;
  bit hold_req = 0;
  bit hold_used = 0;
  bit draining = 0;

  voxel_ray_traversal_3d dut (.*);

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_cell({out_cell_x, out_cell_y, out_cell_z, out_last, out_truncated});
  end

  int rx_wait = 0;
  always @(posedge clk) begin
    if (hold_req && !hold_used) begin
      hold_used <= 1;
      hold_off <= HoldCycles;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else if (draining) begin
      out_stall <= 0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      if (out_valid && !out_stall) rx_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    end
  end

  task automatic write_size(logic [1:0] idx, logic [30:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_size(idx, v);
    @(posedge clk);
  endtask

  task automatic settle;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_ray(logic [31:0] p[6], bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9));
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_start_x <= p[0]; in_start_y <= p[1]; in_start_z <= p[2];
    in_end_x <= p[3]; in_end_y <= p[4]; in_end_z <= p[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_ray(p);
  endtask

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic random_rays(int count, int span);
    logic [31:0] p[6];
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
        p[a] = $urandom;
        if (mode < 7) p[a+3] = near(p[a], span);
        else if (mode < 9) p[a+3] = ($urandom_range(0, 1)) ? p[a] : near(p[a], 300);
        else p[a+3] = $urandom;
      end
      send_ray(p, 0);
    end
  endtask

  initial begin
    logic [31:0] p[6];
    sb = new();
    for (int a = 0; a < 3; a++) sb.set_size(a, 31'd65536);
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    p = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_ray(p, 0);
    p = '{32'h0, 32'h0, 32'h0, 32'h30000, 32'h20000, 32'h10000};
    send_ray(p, 0);
    p = '{32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h0};
    send_ray(p, 0);
    p = '{32'h8000, 32'h8000, 32'h0, 32'hfffe8000, 32'hfffe8000, 32'h0};
    send_ray(p, 0);
    p = '{32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0};
    send_ray(p, 0);
    p = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000};
    send_ray(p, 0);
    p = '{32'h7fff0000, 32'h0, 32'h0, 32'h7fffffff, 32'h0, 32'h0};
    send_ray(p, 0);
    p = '{32'h0, 32'h0, 32'h0, 32'h100000, 32'h100000, 32'h100000};
    send_ray(p, 0);
    settle();

    write_size(vrt_pkg::REG_SIZE_X, 31'd256);
    write_size(vrt_pkg::REG_SIZE_Y, 31'd0);
    write_size(vrt_pkg::REG_SIZE_Z, 31'd100);
    p = '{32'h0, 32'h0, 32'h0, 32'h1000, 32'hfffff000, 32'h800};
    send_ray(p, 0);
    p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000a00, 32'h80000400, 32'h80000300};
    send_ray(p, 0);
    p = '{32'h7fffff00, 32'h7fffff00, 32'h7fffff00, 32'h7ffff000, 32'h7ffff800, 32'h7fffff00};
    send_ray(p, 0);
    random_rays(20, 4000);
    settle();

    write_size(vrt_pkg::REG_SIZE_X, 31'h7fffffff);
    write_size(vrt_pkg::REG_SIZE_Y, 31'h7fffffff);
    write_size(vrt_pkg::REG_SIZE_Z, 31'h7fffffff);
    p = '{32'h80000000, 32'hffffffff, 32'h0, 32'h7fffffff, 32'h0, 32'hffffffff};
    send_ray(p, 0);
    random_rays(20, 32'h40000000);
    settle();

    write_size(vrt_pkg::REG_SIZE_X, 31'd65536);
    write_size(vrt_pkg::REG_SIZE_Y, 31'd65536);
    write_size(vrt_pkg::REG_SIZE_Z, 31'd65536);
    hold_req <= 1;
    random_rays(4, 200000);
    random_rays(60, 600000);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      write_size(vrt_pkg::REG_SIZE_X, 31'($urandom_range(256, 1 << 20)));
      write_size(vrt_pkg::REG_SIZE_Y, 31'($urandom_range(256, 1 << 20)));
      write_size(vrt_pkg::REG_SIZE_Z, 31'($urandom_range(256, 1 << 20)));
      random_rays(40, 1 << 22);
      settle();
    end

    draining <= 1;
    settle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== voxel_ray_traversal_3d.f =====
sv/vrt_pkg.sv
sv/vrt_div.sv
sv/voxel_ray_traversal_3d.sv
verif/testbench.sv
